// ----- src/changed_pixel_escaped_framer_assert.svh -----
// Assertion helpers for the framer modules; only cpef_queue uses them.
`ifndef CHANGED_PIXEL_ESCAPED_FRAMER_ASSERT_SVH
`define CHANGED_PIXEL_ESCAPED_FRAMER_ASSERT_SVH

// Same-cycle implication, disabled while reset is applied.
`define CPEF_ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define CPEF_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- src/cpef_pkg.sv -----
`timescale 1ns / 1ps

package cpef_pkg;

    // Framing bytes
    localparam logic [7:0] FRAME_START = 8'h42;
    localparam logic [7:0] ESC_BYTE    = 8'h65;
    localparam logic [7:0] RSV_HASH    = 8'h23;
    localparam logic [7:0] RSV_START   = 8'h42;
    localparam logic [7:0] RSV_ESC     = 8'h65;
    localparam logic [7:0] RSV_ESC2    = 8'h66;
    localparam logic [7:0] CODE_HASH   = 8'h01;
    localparam logic [7:0] CODE_START  = 8'h02;
    localparam logic [7:0] CODE_ESC    = 8'h03;
    localparam logic [7:0] CODE_ESC2   = 8'h04;

    // Frame field sequence
    localparam logic [2:0] FLD_START = 3'd0;
    localparam logic [2:0] FLD_X     = 3'd1;
    localparam logic [2:0] FLD_Y     = 3'd2;
    localparam logic [2:0] FLD_RED   = 3'd3;
    localparam logic [2:0] FLD_GREEN = 3'd4;
    localparam logic [2:0] FLD_BLUE  = 3'd5;

    // Queue between classifier and serializer
    localparam int QDEPTH  = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef struct packed {
        logic [4:0] pos_x;
        logic [4:0] pos_y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [Q_CNT_W-1:0] count;
        logic               empty;
    } t_q_stat;

    function automatic logic is_reserved(input logic [7:0] b);
        is_reserved = (b == RSV_HASH) || (b == RSV_START) ||
                      (b == RSV_ESC) || (b == RSV_ESC2);
    endfunction

    function automatic logic [7:0] esc_code(input logic [7:0] b);
        unique case (b)
            RSV_HASH:  esc_code = CODE_HASH;
            RSV_START: esc_code = CODE_START;
            RSV_ESC:   esc_code = CODE_ESC;
            default:   esc_code = CODE_ESC2;
        endcase
    endfunction

endpackage

// ----- src/changed_pixel_escaped_framer.sv -----
`timescale 1ns / 1ps

// Changed-pixel framer: each pixel is checked against a shadow copy of the last
// colour sent for its position; an unchanged or off-display pixel is dropped, a
// changed one updates the shadow and leaves as a byte-stuffed frame
// (0x42, x, y, r, g, b) of 6 to 9 bytes, one byte per cycle while m_axis_tready
// holds, with tlast on the final byte. A four-entry queue of changed pixels lets
// input keep flowing while the byte serializer works. After reset the shadow store
// is cleared one entry per cycle, all DISPLAY_WIDTH*DISPLAY_HEIGHT entries (1024
// by default), with s_axis_tready held low.
module changed_pixel_escaped_framer
    import cpef_pkg::*;
#(
    parameter int DISPLAY_WIDTH  = 32,
    parameter int DISPLAY_HEIGHT = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // pos_x[4:0], pos_y[9:5], red[17:10], green[25:18], blue[33:26], zero pad
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_byte[7:0]
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast
);

    t_pixel  in_pix;
    t_pixel  fe_pix;
    t_pixel  q_pix;
    t_q_stat q_stat;
    logic    push;
    logic    pop;

    assign in_pix.pos_x = s_axis_tdata[4:0];
    assign in_pix.pos_y = s_axis_tdata[9:5];
    assign in_pix.red   = s_axis_tdata[17:10];
    assign in_pix.green = s_axis_tdata[25:18];
    assign in_pix.blue  = s_axis_tdata[33:26];

    cpef_front #(
        .DISPLAY_WIDTH (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT(DISPLAY_HEIGHT)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_pixel (in_pix),
        .i_q_stat(q_stat),
        .o_push  (push),
        .o_pixel (fe_pix)
    );

    cpef_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_pixel(fe_pix),
        .i_pop  (pop),
        .o_pixel(q_pix),
        .o_stat (q_stat)
    );

    cpef_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(!q_stat.empty),
        .i_pixel(q_pix),
        .o_pop  (pop),
        .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready),
        .o_byte (m_axis_tdata),
        .o_last (m_axis_tlast)
    );

endmodule

// ----- src/cpef_front.sv -----
`timescale 1ns / 1ps

module cpef_front
    import cpef_pkg::*;
#(
    parameter int DISPLAY_WIDTH  = 32,
    parameter int DISPLAY_HEIGHT = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_pixel  i_pixel,
    input  t_q_stat i_q_stat,
    output logic    o_push,
    output t_pixel  o_pixel
);

    localparam int DEPTH = DISPLAY_WIDTH * DISPLAY_HEIGHT;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [8:0]  W9  = 9'(DISPLAY_WIDTH);
    localparam logic [8:0]  H9  = 9'(DISPLAY_HEIGHT);
    localparam logic [16:0] W17 = 17'(DISPLAY_WIDTH);

    logic [23:0]      mem [DEPTH];
    logic [23:0]      r_rd_data;
    logic             r_clearing;
    logic [IDX_W-1:0] r_clr_addr;
    logic             r_s1_valid;
    logic [IDX_W-1:0] r_s1_idx;
    t_pixel           r_s1_pix;
    logic             r_fwd_valid;
    logic [IDX_W-1:0] r_fwd_idx;
    logic [23:0]      r_fwd_data;

    logic             accept;
    logic             in_range;
    logic [16:0]      idx_full;
    logic [IDX_W-1:0] idx;
    logic [23:0]      s1_colour;
    logic [23:0]      old_colour;
    logic             changed;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [23:0]      wdata;

    // Classify the incoming pixel
    assign o_ready  = !r_clearing &&
                      ({1'b0, i_q_stat.count} + {{Q_CNT_W{1'b0}}, r_s1_valid})
                      < (Q_CNT_W + 1)'(QDEPTH);
    assign accept   = i_valid && o_ready;
    assign in_range = ({4'b0, i_pixel.pos_x} < W9) && ({4'b0, i_pixel.pos_y} < H9);
    assign idx_full = 17'(i_pixel.pos_y) * W17 + 17'(i_pixel.pos_x);
    assign idx      = idx_full[IDX_W-1:0];

    // Compare with the shadow entry, taking the last write when the read missed it
    assign s1_colour  = {r_s1_pix.red, r_s1_pix.green, r_s1_pix.blue};
    assign old_colour = (r_fwd_valid && (r_fwd_idx == r_s1_idx)) ? r_fwd_data : r_rd_data;
    assign changed    = r_s1_valid && (old_colour != s1_colour);
    assign o_push     = changed;
    assign o_pixel    = r_s1_pix;

    assign we    = r_clearing || changed;
    assign waddr = r_clearing ? r_clr_addr : r_s1_idx;
    assign wdata = r_clearing ? 24'd0 : s1_colour;

    // Shadow store
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd_data <= mem[idx];
    end

    // Clear pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == LAST_IDX) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Advance the compare stage and hold the latest write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept && in_range;
            if (changed) begin
                r_fwd_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx <= idx;
        r_s1_pix <= i_pixel;
        if (changed) begin
            r_fwd_idx  <= r_s1_idx;
            r_fwd_data <= s1_colour;
        end
    end

endmodule

// ----- src/cpef_queue.sv -----
`timescale 1ns / 1ps
`include "changed_pixel_escaped_framer_assert.svh"

module cpef_queue
    import cpef_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_pixel  i_pixel,
    input  logic    i_pop,
    output t_pixel  o_pixel,
    output t_q_stat o_stat
);

    t_pixel             r_mem [QDEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_pixel      = r_mem[r_rd_ptr];
    assign o_stat.count = r_count;
    assign o_stat.empty = (r_count == '0);

    // Store pushed pixels
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_pixel;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `CPEF_ASSERT_IMPLY(a_no_overflow, i_clk, i_rst_n, i_push && !i_pop, r_count < Q_CNT_W'(QDEPTH), "queue push while full")
    `CPEF_ASSERT_IMPLY(a_no_underflow, i_clk, i_rst_n, i_pop, r_count != '0, "queue pop while empty")
    `CPEF_ASSERT_NEXT(a_count_track, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "queue count did not grow on push")

endmodule

// ----- src/cpef_back.sv -----
`timescale 1ns / 1ps

module cpef_back
    import cpef_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_pixel     i_pixel,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_last
);

    logic [2:0] r_field;
    logic       r_esc;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic [2:0] n_field;
    logic       n_esc;
    logic [7:0] n_out_byte;
    logic       n_out_last;
    logic       load;
    logic       advance;
    logic [7:0] cur;
    logic       rsv;

    // Select the byte of the current field
    always_comb begin
        unique case (r_field)
            FLD_START: cur = FRAME_START;
            FLD_X:     cur = {3'b0, i_pixel.pos_x};
            FLD_Y:     cur = {3'b0, i_pixel.pos_y};
            FLD_RED:   cur = i_pixel.red;
            FLD_GREEN: cur = i_pixel.green;
            default:   cur = i_pixel.blue;
        endcase
    end

    assign rsv  = (r_field != FLD_START) && is_reserved(cur);
    assign load = i_valid && (!r_out_valid || i_ready);

    // Stuff the byte: escape first, then its code
    always_comb begin
        n_esc   = r_esc;
        advance = 1'b0;
        if (rsv && !r_esc) begin
            n_out_byte = ESC_BYTE;
            n_esc      = 1'b1;
        end else if (r_esc) begin
            n_out_byte = esc_code(cur);
            n_esc      = 1'b0;
            advance    = 1'b1;
        end else begin
            n_out_byte = cur;
            advance    = 1'b1;
        end
        n_out_last = advance && (r_field == FLD_BLUE);
        n_field    = advance ? ((r_field == FLD_BLUE) ? FLD_START : r_field + 1'b1) : r_field;
    end

    assign o_pop   = load && n_out_last;
    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;

    // Hold sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field     <= FLD_START;
            r_esc       <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_field     <= n_field;
            r_esc       <= n_esc;
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= n_out_byte;
            r_out_last <= n_out_last;
        end
    end

endmodule

// ----- tb/pixel_frame_checker.sv -----
`timescale 1ns / 1ps

module pixel_frame_checker
    import cpef_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_pix_tvalid,
    input  logic        i_pix_tready,
    // pos_x[4:0], pos_y[9:5], red[17:10], green[25:18], blue[33:26], zero pad
    input  logic [39:0] i_pix_tdata,
    input  logic        i_byte_tvalid,
    input  logic        i_byte_tready,
    // out_byte[7:0]
    input  logic [7:0]  i_byte_tdata,
    input  logic        i_byte_tlast,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_frames,
    output int          o_bytes
);

    localparam int DISP_W      = 32;
    localparam int DISP_H      = 32;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_frame_byte;

    // Bytes still owed by the block, oldest first
    t_frame_byte frame_bytes_due[$];
    // Last colour framed for each position, {red, green, blue}
    logic [23:0] sent_rgb [0:DISP_W*DISP_H-1];

    // Queue one frame byte, escaping the reserved values
    task automatic push_escaped(input logic [7:0] b, input logic is_last);
        logic [7:0] code;
        logic       reserved;
        reserved = 1'b1;
        code     = 8'h00;
        case (b)
            RSV_HASH:  code = CODE_HASH;
            RSV_START: code = CODE_START;
            RSV_ESC:   code = CODE_ESC;
            RSV_ESC2:  code = CODE_ESC2;
            default:   reserved = 1'b0;
        endcase
        if (reserved) begin
            frame_bytes_due.push_back('{data: ESC_BYTE, last: 1'b0});
            frame_bytes_due.push_back('{data: code, last: is_last});
        end else begin
            frame_bytes_due.push_back('{data: b, last: is_last});
        end
    endtask

    // Compare the pixel with its shadow entry and queue the frame if it changed
    task automatic frame_changed_pixel(input logic [39:0] d);
        logic [4:0]  x;
        logic [4:0]  y;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [23:0] rgb;
        int          pos;
        x   = d[4:0];
        y   = d[9:5];
        r   = d[17:10];
        g   = d[25:18];
        b   = d[33:26];
        rgb = {r, g, b};
        if (int'(x) < DISP_W && int'(y) < DISP_H) begin
            pos = int'(y) * DISP_W + int'(x);
            if (sent_rgb[pos] != rgb) begin
                sent_rgb[pos] = rgb;
                o_frames++;
                frame_bytes_due.push_back('{data: FRAME_START, last: 1'b0});
                push_escaped({3'b000, x}, 1'b0);
                push_escaped({3'b000, y}, 1'b0);
                push_escaped(r, 1'b0);
                push_escaped(g, 1'b0);
                push_escaped(b, 1'b1);
            end
        end
    endtask

    task automatic note_failure(input string what, input t_frame_byte want);
        o_fail_count++;
        if (o_fail_count <= MAX_REPORTS) begin
            $display("[%0t] %s: expected byte %02h last %0b, got byte %02h last %0b",
                     $realtime, what, want.data, want.last, i_byte_tdata, i_byte_tlast);
        end
    endtask

    // Predict on accepted pixels, then check the accepted byte
    always @(posedge i_clk) begin
        t_frame_byte want;
        if (!i_rst_n) begin
            frame_bytes_due.delete();
            for (int i = 0; i < DISP_W * DISP_H; i++) begin
                sent_rgb[i] = 24'h000000;
            end
            o_fail_count = 0;
            o_frames     = 0;
            o_bytes      = 0;
        end else begin
            if (i_pix_tvalid && i_pix_tready) begin
                frame_changed_pixel(i_pix_tdata);
            end
            if (i_byte_tvalid && i_byte_tready) begin
                o_bytes++;
                if (frame_bytes_due.size() == 0) begin
                    note_failure("byte with nothing due", '{data: 8'h00, last: 1'b0});
                end else begin
                    want = frame_bytes_due.pop_front();
                    if (i_byte_tdata !== want.data || i_byte_tlast !== want.last) begin
                        note_failure("byte mismatch", want);
                    end
                end
            end
        end
        o_pending = frame_bytes_due.size();
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // pos_x[4:0], pos_y[9:5], red[17:10], green[25:18], blue[33:26], zero pad
    logic [39:0] s_axis_tdata  = 40'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // out_byte[7:0]
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    int fail_count;
    int bytes_due;
    int frames_seen;
    int bytes_seen;

    int idle_pct  = 0;
    int stall_pct = 0;
    int pixels_sent = 0;

    changed_pixel_escaped_framer u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    pixel_frame_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix_tvalid (s_axis_tvalid),
        .i_pix_tready (s_axis_tready),
        .i_pix_tdata  (s_axis_tdata),
        .i_byte_tvalid(m_axis_tvalid),
        .i_byte_tready(m_axis_tready),
        .i_byte_tdata (m_axis_tdata),
        .i_byte_tlast (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (bytes_due),
        .o_frames     (frames_seen),
        .o_bytes      (bytes_seen)
    );

    always #1 i_clk = ~i_clk;

    // Stall the byte output at the current rate
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Hard stop for a hung block
    initial begin
        #400000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [39:0] pack_pixel(input logic [4:0] x, input logic [4:0] y,
                                               input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b);
        return {6'd0, b, g, r, y, x};
    endfunction

    // Favor the reserved and extreme values in colour bytes
    function automatic logic [7:0] pick_colour_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h23;
            3:       return 8'h42;
            4:       return 8'h65;
            5:       return 8'h66;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one pixel after a random gap, hold until accepted; call at a falling edge
    task automatic send_pixel(input logic [39:0] d);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        pixels_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (bytes_due != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        logic [39:0] prev_pixel;
        logic [9:0]  hot_pos [6];
        logic [9:0]  pos;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: black after reset, extremes, every reserved byte, repeats
        send_pixel(pack_pixel(5'd0,  5'd0,  8'h00, 8'h00, 8'h00));
        send_pixel(pack_pixel(5'd31, 5'd31, 8'h00, 8'h00, 8'h00));
        send_pixel(pack_pixel(5'd0,  5'd0,  8'hFF, 8'hFF, 8'hFF));
        send_pixel(pack_pixel(5'd0,  5'd0,  8'hFF, 8'hFF, 8'hFF));
        send_pixel(pack_pixel(5'd31, 5'd31, 8'h23, 8'h42, 8'h65));
        send_pixel(pack_pixel(5'd31, 5'd0,  8'h66, 8'h23, 8'h42));
        send_pixel(pack_pixel(5'd0,  5'd31, 8'h65, 8'h66, 8'h23));
        send_pixel(pack_pixel(5'd5,  5'd10, 8'h42, 8'h65, 8'h66));
        send_pixel(pack_pixel(5'd0,  5'd0,  8'h00, 8'h00, 8'h00));
        send_pixel(pack_pixel(5'd0,  5'd0,  8'h00, 8'h00, 8'h00));
        send_pixel(pack_pixel(5'd21, 5'd10, 8'hAA, 8'h55, 8'h01));
        send_pixel(pack_pixel(5'd10, 5'd21, 8'h55, 8'hAA, 8'hFE));
        send_pixel(pack_pixel(5'd31, 5'd31, 8'h23, 8'h42, 8'h65));
        send_pixel(pack_pixel(5'd31, 5'd31, 8'h23, 8'h42, 8'h64));
        send_pixel(pack_pixel(5'd1,  5'd1,  8'h00, 8'h00, 8'h01));
        s_axis_tvalid <= 1'b0;
        wait_drained();
        prev_pixel = pack_pixel(5'd1, 5'd1, 8'h00, 8'h00, 8'h01);

        // Random: no idling, sender idle, receiver stall, both
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 64; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 64; end
                default: begin idle_pct = 21; stall_pct = 21; end
            endcase
            foreach (hot_pos[i]) begin
                hot_pos[i] = 10'($urandom_range(0, 1023));
            end
            for (int n = 0; n < 45; n++) begin
                // Repeat the last pixel now and then to hit the unchanged case
                if ($urandom_range(0, 99) < 25) begin
                    send_pixel(prev_pixel);
                end else begin
                    if ($urandom_range(0, 99) < 70) begin
                        pos = hot_pos[$urandom_range(0, 5)];
                    end else begin
                        pos = 10'($urandom_range(0, 1023));
                    end
                    if ($urandom_range(0, 99) < 8) begin
                        prev_pixel = pack_pixel(pos[4:0], pos[9:5], 8'h00, 8'h00, 8'h00);
                    end else begin
                        prev_pixel = pack_pixel(pos[4:0], pos[9:5], pick_colour_byte(),
                                                pick_colour_byte(), pick_colour_byte());
                    end
                    send_pixel(prev_pixel);
                end
            end
            s_axis_tvalid <= 1'b0;
            // Hold off the sender until every frame byte is out
            wait_drained();
        end

        // Let any stray output show up
        repeat (40) @(negedge i_clk);

        $display("Sent %0d pixels under four idling mixes; %0d changed pixels framed",
                 pixels_sent, frames_seen);
        $display("Checked %0d output bytes, %0d still owed", bytes_seen, bytes_due);
        if (fail_count == 0 && bytes_due == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
